/* rtl/triangle_unit_normal_defines.svh */
// Assertion macros used by the checker tun_checker.
// No dependencies.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define TUN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/tun_pkg.sv */
// Shared types and widths for the triangle unit-normal pipeline.
// No dependencies.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned OutW   = 32;
  localparam int unsigned CrossW = 67;
  localparam int unsigned MagW   = 66;
  localparam int unsigned TW     = 31;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned QW     = 31;
  localparam int unsigned NumDepth = 12;

  // Data that each square-root cell hands to its neighbor.
  typedef struct packed {
    logic [2:0]      neg;
    logic            degen;
    logic [TW-1:0]   tx;
    logic [TW-1:0]   ty;
    logic [TW-1:0]   tz;
    logic [SumW-1:0] rem;
    logic [RootW-1:0] root;
  } sq_cell_t;
endpackage

/* rtl/tun_sqrt_cell.sv */
// One restoring square-root step; a cell in the root chain.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic              en,
  input  tun_pkg::sq_cell_t d_i,
  output logic              vld_o,
  output tun_pkg::sq_cell_t d_o
);
  // bit position tested in this step: root bit 31-Step
  localparam int unsigned Bp = tun_pkg::RootW - 1 - Step;
  logic [tun_pkg::SumW+1:0] trial;
  logic [tun_pkg::SumW+1:0] remw;
  tun_pkg::sq_cell_t d_nxt;
  tun_pkg::sq_cell_t d_r;
  logic vld_r;

  always_comb begin
    d_nxt = d_i;
    // trial = (2*root + 2^Bp) << Bp
    trial = (({{(tun_pkg::SumW+2-tun_pkg::RootW){1'b0}}, d_i.root} << 1)
            + ({{(tun_pkg::SumW+1){1'b0}}, 1'b1} << Bp)) << Bp;
    remw = {2'b00, d_i.rem};
    if (remw >= trial) begin
      d_nxt.rem  = tun_pkg::SumW'(remw - trial);
      d_nxt.root = d_i.root | (tun_pkg::RootW'(1) << Bp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end
  assign vld_o = vld_r;
  assign d_o   = d_r;
endmodule

/* rtl/tun_div_cell.sv */
// One restoring division step for three quotients at once.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_div_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [tun_pkg::RootW-1:0]  den_i,
  input  logic [2:0]                 neg_i,
  input  logic                       degen_i,
  input  logic [3*(tun_pkg::RootW+1)-1:0] rem_i,
  input  logic [3*tun_pkg::QW-1:0]   q_i,
  input  logic [3*tun_pkg::QW-1:0]   num_i,
  output logic                       vld_o,
  output logic [tun_pkg::RootW-1:0]  den_o,
  output logic [2:0]                 neg_o,
  output logic                       degen_o,
  output logic [3*(tun_pkg::RootW+1)-1:0] rem_o,
  output logic [3*tun_pkg::QW-1:0]   q_o,
  output logic [3*tun_pkg::QW-1:0]   num_o
);
  localparam int unsigned RW = tun_pkg::RootW + 1;
  localparam int unsigned QW = tun_pkg::QW;
  logic [3*RW-1:0] rem_nxt;
  logic [3*QW-1:0] q_nxt;
  logic vld_r, degen_r;
  logic [tun_pkg::RootW-1:0] den_r;
  logic [2:0] neg_r;
  logic [3*RW-1:0] rem_r;
  logic [3*QW-1:0] q_r, num_r;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [RW-1:0] sh;
      sh = {rem_i[i*RW +: RW-1], num_i[i*QW + QW-1]};
      if (sh >= {1'b0, den_i}) begin
        rem_nxt[i*RW +: RW] = sh - {1'b0, den_i};
        q_nxt[i*QW +: QW]   = {q_i[i*QW +: QW-1], 1'b1};
      end else begin
        rem_nxt[i*RW +: RW] = sh;
        q_nxt[i*QW +: QW]   = {q_i[i*QW +: QW-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_i;
      neg_r   <= neg_i;
      degen_r <= degen_i;
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      for (int i = 0; i < 3; i++) begin
        num_r[i*QW +: QW] <= {num_i[i*QW +: QW-1], 1'b0};
      end
    end
  end
  assign vld_o = vld_r; assign den_o = den_r; assign neg_o = neg_r;
  assign degen_o = degen_r; assign rem_o = rem_r; assign q_o = q_r;
  assign num_o = num_r;
endmodule

/* rtl/triangle_unit_normal.sv */
// Top level of the triangle unit-normal pipeline.
// Depends on tun_pkg, tun_sqrt_cell and tun_div_cell.
`timescale 1ns / 1ps
// Unit face normal: takes one triangle beat per cycle and returns one normal beat per
// triangle, in order. The pipeline has 6 front-end stages (edges, products, cross
// sums, magnitude alignment, squares, sum) plus 32 square-root cells plus 61
// division cells plus the output register; throughput is one triangle per cycle, set by
// the cell chains, which advance all together whenever the output register is free or
// being drained. A stall on out_tready freezes the whole chain. Each component is
// signed Q2.30, rounded toward zero; a zero cross product gives a zero vector with
// degenerate set.
module triangle_unit_normal #(
  parameter int unsigned CoordW = tun_pkg::CoordW
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: ax, ay, az, bx, by, bz, cx, cy, cz (lowest first), 32 bits each
  input  logic [9*CoordW-1:0] in_tdata,
  // tuser: winding_forward
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: nx, ny, nz (lowest first), 32 bits each
  output logic [3*tun_pkg::OutW-1:0] out_tdata,
  // tuser: degenerate
  output logic out_tuser
);
  localparam int unsigned EW = CoordW + 1;
  localparam int unsigned PW = 2*EW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned MW = CW - 1;
  localparam int unsigned LW = $clog2(MW+1);
  localparam int unsigned TW = tun_pkg::TW;
  localparam int unsigned RootW = tun_pkg::RootW;
  localparam int unsigned QW = tun_pkg::QW;
  localparam int unsigned RW = RootW + 1;
  localparam int unsigned NSq = RootW;
  // one cell per numerator bit: TW bits of t followed by 30 fraction zeros
  localparam int unsigned NDiv = TW + 30;

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  // stage 1: edges
  logic s1_v_r, s1_w_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_w_r <= in_tuser;
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'($signed(in_tdata[(3+i)*CoordW +: CoordW]))
                 - EW'($signed(in_tdata[i*CoordW +: CoordW]));
        e2_r[i] <= EW'($signed(in_tdata[(6+i)*CoordW +: CoordW]))
                 - EW'($signed(in_tdata[i*CoordW +: CoordW]));
      end
    end
  end

  // stage 2: six products
  logic s2_v_r, s2_w_r;
  logic signed [PW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_w_r <= s1_w_r;
      p_r[0] <= e1_r[1] * e2_r[2]; p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0]; p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1]; p_r[5] <= e1_r[1] * e2_r[0];
    end
  end

  // stage 3: cross components as magnitude and sign
  logic s3_v_r;
  logic [MW-1:0] m_r [3];
  logic [2:0] neg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [CW-1:0] c;
        c = CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
        m_r[i]   <= c[CW-1] ? MW'(-c) : MW'(c);
        neg_r[i] <= c[CW-1] ^ !s2_w_r;
      end
    end
  end

  // stage 4: align on the bit length of the largest magnitude
  logic s4_v_r, s4_dg_r;
  logic [2:0] s4_neg_r;
  logic [TW-1:0] t_r [3];
  logic [MW-1:0] orv;
  logic [LW-1:0] len;
  always_comb begin
    orv = m_r[0] | m_r[1] | m_r[2];
    len = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) len = LW'(b + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg_r <= neg_r;
      s4_dg_r  <= (len == '0);
      for (int i = 0; i < 3; i++) begin
        if (len <= LW'(TW)) t_r[i] <= TW'(m_r[i] << (LW'(TW) - len));
        else t_r[i] <= TW'(m_r[i] >> (len - LW'(TW)));
      end
    end
  end

  // stage 5: squares; stage 6: sum
  logic s5_v_r, s5_dg_r;
  logic [2:0] s5_neg_r;
  logic [TW-1:0] t5_r [3];
  logic [2*TW-1:0] sq_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_neg_r <= s4_neg_r; s5_dg_r <= s4_dg_r;
      for (int i = 0; i < 3; i++) begin
        t5_r[i] <= t_r[i];
        sq_r[i] <= t_r[i] * t_r[i];
      end
    end
  end
  tun_pkg::sq_cell_t sq_d [NSq+1];
  logic sq_v [NSq+1];
  logic s6_v_r;
  tun_pkg::sq_cell_t s6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_r.neg <= s5_neg_r; s6_r.degen <= s5_dg_r;
      s6_r.tx <= t5_r[0]; s6_r.ty <= t5_r[1]; s6_r.tz <= t5_r[2];
      s6_r.rem <= tun_pkg::SumW'(sq_r[0]) + tun_pkg::SumW'(sq_r[1])
                + tun_pkg::SumW'(sq_r[2]);
      s6_r.root <= '0;
    end
  end
  assign sq_d[0] = s6_r;
  assign sq_v[0] = s6_v_r;

  // square-root chain: one root bit per cell
  for (genvar k = 0; k < NSq; k++) begin : g_sq
    tun_sqrt_cell #(.Step(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_i(sq_v[k]), .en(en),
      .d_i(sq_d[k]), .vld_o(sq_v[k+1]), .d_o(sq_d[k+1])
    );
  end

  // division chain: numerator t << 30 is 61 bits, one cell per bit; the quotient
  // never exceeds 2^30, so a QW-bit window holds it
  logic dv_v [NDiv+1];
  logic [RootW-1:0] dv_den [NDiv+1];
  logic [2:0] dv_neg [NDiv+1];
  logic dv_dg [NDiv+1];
  logic [3*RW-1:0] dv_rem [NDiv+1];
  logic [3*QW-1:0] dv_q [NDiv+1];
  logic [3*QW-1:0] dv_num [NDiv+1];
  assign dv_v[0] = sq_v[NSq];
  assign dv_den[0] = sq_d[NSq].root;
  assign dv_neg[0] = sq_d[NSq].neg;
  assign dv_dg[0] = sq_d[NSq].degen;
  assign dv_rem[0] = '0;
  assign dv_q[0] = '0;
  assign dv_num[0] = {sq_d[NSq].tz, sq_d[NSq].ty, sq_d[NSq].tx};

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    tun_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dv_v[k]), .den_i(dv_den[k]),
      .neg_i(dv_neg[k]), .degen_i(dv_dg[k]), .rem_i(dv_rem[k]), .q_i(dv_q[k]),
      .num_i(dv_num[k]), .vld_o(dv_v[k+1]), .den_o(dv_den[k+1]),
      .neg_o(dv_neg[k+1]), .degen_o(dv_dg[k+1]), .rem_o(dv_rem[k+1]),
      .q_o(dv_q[k+1]), .num_o(dv_num[k+1])
    );
  end

  // output register: apply signs, zero the degenerate case
  logic [3*tun_pkg::OutW-1:0] out_d_r;
  logic out_u_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_v[NDiv];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_u_r <= dv_dg[NDiv];
      for (int i = 0; i < 3; i++) begin
        logic [tun_pkg::OutW-1:0] q;
        q = tun_pkg::OutW'(dv_q[NDiv][i*QW +: QW]);
        if (dv_dg[NDiv]) out_d_r[i*tun_pkg::OutW +: tun_pkg::OutW] <= '0;
        else if (dv_neg[NDiv][i]) out_d_r[i*tun_pkg::OutW +: tun_pkg::OutW] <= -q;
        else out_d_r[i*tun_pkg::OutW +: tun_pkg::OutW] <= q;
      end
    end
  end
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;
endmodule

/* rtl/tun_checker.sv */
// Port-level checker for triangle_unit_normal, bound to the top level.
// Depends on triangle_unit_normal_defines.svh.
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"
module tun_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [95:0] out_tdata,
  input logic out_tuser
);
  `TUN_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `TUN_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_tvalid, in_tready)
  `TUN_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
